>>> hw/rtl/lfuc_pkg.sv
`timescale 1ns / 1ps

package lfuc_pkg;

    // request codes
    localparam logic [2:0] OP_GET      = 3'd0;
    localparam logic [2:0] OP_PUT      = 3'd1;
    localparam logic [2:0] OP_ERASE    = 3'd2;
    localparam logic [2:0] OP_CONTAINS = 3'd3;
    localparam logic [2:0] OP_TICK     = 3'd4;

    // configuration register indexes
    localparam logic REG_CAPACITY    = 1'b0;
    localparam logic REG_DEFAULT_TTL = 1'b1;

    localparam int TIME_W  = 48;
    localparam int USES_W  = 32;
    localparam int STAT_W  = 32;
    localparam int TTL_W   = 32;
    localparam int FIELD_W = 64;

    typedef enum logic [2:0] {
        C_NOP      = 3'd0,
        C_TOUCH    = 3'd1,
        C_UPDATE   = 3'd2,
        C_KILL_HIT = 3'd3,
        C_KILL_MIN = 3'd4,
        C_INSERT   = 3'd5
    } t_cmd_op;

    // broadcast from the controller to every cell
    typedef struct packed {
        t_cmd_op             op;
        logic [TIME_W-1:0]   stamp;
        logic                expires;
        logic [TIME_W-1:0]   deadline;
    } t_cmd;

    // scan token handed from cell to cell
    typedef struct packed {
        logic                tv;
        logic                hit;
        logic                hexp;
        logic [TIME_W-1:0]   hdl;
        logic                free;
        logic                mok;
        logic [USES_W-1:0]   muses;
        logic [TIME_W-1:0]   mstamp;
    } t_tok;

endpackage

>>> hw/rtl/lfuc_req_if.sv
`timescale 1ns / 1ps

interface lfuc_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic [63:0]        req_key;
    logic [63:0]        value_in;
    logic signed [32:0] ttl;

    modport source (output valid, output req_type, output req_key, output value_in,
                    output ttl, input ready);
    modport sink   (input valid, input req_type, input req_key, input value_in,
                    input ttl, output ready);
endinterface

>>> hw/rtl/lfuc_rsp_if.sv
`timescale 1ns / 1ps

interface lfuc_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [63:0] value_out;
    logic [6:0]  entry_count;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] expire_total;
    logic [31:0] evict_total;

    modport source (output valid, output found, output value_out, output entry_count,
                    output hit_total, output miss_total, output expire_total,
                    output evict_total, input ready);
    modport sink   (input valid, input found, input value_out, input entry_count,
                    input hit_total, input miss_total, input expire_total,
                    input evict_total, output ready);
endinterface

>>> hw/rtl/lfuc_cell.sv
`timescale 1ns / 1ps

module lfuc_cell #(
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lfuc_pkg::t_tok        i_tok,
    input  logic [VALUE_BITS-1:0] i_tval,
    output lfuc_pkg::t_tok        o_tok,
    output logic [VALUE_BITS-1:0] o_tval,
    input  lfuc_pkg::t_cmd        i_cmd,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_wval
);

    logic                          r_valid;
    logic                          r_first;
    logic [KEY_BITS-1:0]           r_key;
    logic [VALUE_BITS-1:0]         r_value;
    logic [lfuc_pkg::USES_W-1:0]   r_uses;
    logic [lfuc_pkg::TIME_W-1:0]   r_stamp;
    logic                          r_expires;
    logic [lfuc_pkg::TIME_W-1:0]   r_deadline;
    lfuc_pkg::t_tok                r_tok;
    logic [VALUE_BITS-1:0]         r_tval;

    lfuc_pkg::t_tok                n_tok;
    logic [VALUE_BITS-1:0]         n_tval;
    logic                          w_match;
    logic [lfuc_pkg::USES_W-1:0]   w_uses_inc;

    assign w_match    = r_valid && (r_key == i_key);
    assign w_uses_inc = (&r_uses) ? r_uses : r_uses + lfuc_pkg::USES_W'(1);

    always_comb begin
        n_tok  = i_tok;
        n_tval = i_tval;
        if (w_match) begin
            n_tok.hit  = 1'b1;
            n_tok.hexp = r_expires;
            n_tok.hdl  = r_deadline;
            n_tval     = r_value;
        end
        // keep the lowest count, oldest stamp on a tie
        if (r_valid && (!i_tok.mok || r_uses < i_tok.muses ||
                        (r_uses == i_tok.muses && r_stamp < i_tok.mstamp))) begin
            n_tok.mok    = 1'b1;
            n_tok.muses  = r_uses;
            n_tok.mstamp = r_stamp;
        end
        if (!r_valid) begin
            n_tok.free = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
        r_tval <= n_tval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_first <= 1'b0;
        end else begin
            // mark the first free cell the token passes
            if (i_tok.tv) begin
                r_first <= !r_valid && !i_tok.free;
            end
            case (i_cmd.op)
                lfuc_pkg::C_TOUCH: begin
                    if (w_match) begin
                        r_uses  <= w_uses_inc;
                        r_stamp <= i_cmd.stamp;
                    end
                end
                lfuc_pkg::C_UPDATE: begin
                    if (w_match) begin
                        r_value    <= i_wval;
                        r_expires  <= i_cmd.expires;
                        r_deadline <= i_cmd.deadline;
                        r_uses     <= w_uses_inc;
                        r_stamp    <= i_cmd.stamp;
                    end
                end
                lfuc_pkg::C_KILL_HIT: begin
                    if (w_match) begin
                        r_valid <= 1'b0;
                    end
                end
                lfuc_pkg::C_KILL_MIN: begin
                    if (r_valid && r_stamp == i_cmd.stamp) begin
                        r_valid <= 1'b0;
                    end
                end
                lfuc_pkg::C_INSERT: begin
                    if (r_first) begin
                        r_valid    <= 1'b1;
                        r_first    <= 1'b0;
                        r_key      <= i_key;
                        r_value    <= i_wval;
                        r_uses     <= lfuc_pkg::USES_W'(1);
                        r_stamp    <= i_cmd.stamp;
                        r_expires  <= i_cmd.expires;
                        r_deadline <= i_cmd.deadline;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_tok  = r_tok;
    assign o_tval = r_tval;

endmodule

>>> hw/rtl/lfu_cache_with_expiry_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// i_req     in   valid/ready        req_type, req_key, value_in, ttl
// o_rsp     out  valid/ready        found, value_out, entry_count, four totals
// i_cfg_*   in   i_cfg_we only      i_cfg_idx selects capacity or default_ttl
//
// One request at a time. A tick, an unused code or a put at capacity 0 goes
// straight to done; others scan SLOTS cells, then decide, apply where a cell
// changes, and done; each evicted stored entry adds an apply and a new scan.
// Synchronous reset (active low) clears cells, counters, time and default TTL.
// A stalled result holds in the output register; the next request runs, then
// holds in the done state until that register drains.

module lfu_cache_with_expiry_core #(
    parameter int SLOTS      = 64,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfuc_req_if.sink    i_req,
    lfuc_rsp_if.source  o_rsp,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CAP_W = (CNT_W + 1 > 7) ? CNT_W + 1 : 7;
    localparam int TW    = lfuc_pkg::TIME_W;
    localparam int SW    = lfuc_pkg::STAT_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_APPLY  = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state                      r_state;
    logic [6:0]                  r_capacity;
    logic [lfuc_pkg::TTL_W-1:0]  r_default_ttl;
    logic [2:0]                  r_type;
    logic [KEY_BITS-1:0]         r_key;
    logic [VALUE_BITS-1:0]       r_wval;
    logic [lfuc_pkg::TTL_W-1:0]  r_eff;
    logic [TW-1:0]               r_time;
    logic [TW-1:0]               r_tc;
    logic [TW-1:0]               r_new_stamp;
    logic [CNT_W-1:0]            r_count;
    logic [CAP_W-1:0]            r_total;
    logic                        r_stamped;
    logic                        r_pending;
    logic                        r_again;
    logic                        r_inject;
    lfuc_pkg::t_tok              r_tok;
    logic [VALUE_BITS-1:0]       r_tval;
    lfuc_pkg::t_cmd              r_cmd;
    logic                        r_found;
    logic [VALUE_BITS-1:0]       r_vout;
    logic [SW-1:0]               r_hit;
    logic [SW-1:0]               r_miss;
    logic [SW-1:0]               r_expire;
    logic [SW-1:0]               r_evict;
    logic                        r_ovalid;
    logic                        r_ofound;
    logic [63:0]                 r_ovalue;
    logic [6:0]                  r_ocount;
    logic [SW-1:0]               r_ohit;
    logic [SW-1:0]               r_omiss;
    logic [SW-1:0]               r_oexpire;
    logic [SW-1:0]               r_oevict;

    lfuc_pkg::t_tok              w_tok  [SLOTS+1];
    logic [VALUE_BITS-1:0]       w_tval [SLOTS+1];
    logic [CAP_W-1:0]            w_cap_ext;
    logic [CAP_W-1:0]            w_cap;
    logic [CAP_W-1:0]            w_cnt_ext;
    logic                        w_expired;
    logic                        w_accept;
    logic [TW-1:0]               w_deadline;

    assign w_cap_ext  = CAP_W'(r_capacity);
    assign w_cap      = (w_cap_ext > CAP_W'(SLOTS)) ? CAP_W'(SLOTS) : w_cap_ext;
    assign w_cnt_ext  = CAP_W'(r_count);
    assign w_expired  = r_tok.hexp && (r_time >= r_tok.hdl);
    assign w_deadline = TW'(r_time + TW'(r_eff));
    assign w_accept   = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        w_tok[0]    = '0;
        w_tok[0].tv = r_inject;
        w_tval[0]   = '0;
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        lfuc_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .i_tval  (w_tval[g]),
            .o_tok   (w_tok[g+1]),
            .o_tval  (w_tval[g+1]),
            .i_cmd   (r_cmd),
            .i_key   (r_key),
            .i_wval  (r_wval)
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity    <= 7'd64;
            r_default_ttl <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lfuc_pkg::REG_CAPACITY:    r_capacity    <= i_cfg_data[6:0];
                lfuc_pkg::REG_DEFAULT_TTL: r_default_ttl <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_time    <= '0;
            r_tc      <= '0;
            r_count   <= '0;
            r_hit     <= '0;
            r_miss    <= '0;
            r_expire  <= '0;
            r_evict   <= '0;
            r_inject  <= 1'b0;
            r_again   <= 1'b0;
            r_cmd     <= '0;
            r_ovalid  <= 1'b0;
            r_stamped <= 1'b0;
            r_pending <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_inject <= 1'b0;
            if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_type    <= i_req.req_type;
                        r_key     <= i_req.req_key[KEY_BITS-1:0];
                        r_wval    <= i_req.value_in[VALUE_BITS-1:0];
                        r_eff     <= i_req.ttl[32] ? r_default_ttl : i_req.ttl[31:0];
                        r_found   <= 1'b0;
                        r_vout    <= '0;
                        r_stamped <= 1'b0;
                        r_pending <= 1'b1;
                        r_state   <= S_DONE;
                        case (i_req.req_type)
                            lfuc_pkg::OP_TICK: begin
                                r_time <= r_time + TW'(1);
                            end
                            lfuc_pkg::OP_GET, lfuc_pkg::OP_ERASE,
                            lfuc_pkg::OP_CONTAINS: begin
                                r_inject <= 1'b1;
                                r_state  <= S_SCAN;
                            end
                            lfuc_pkg::OP_PUT: begin
                                if (w_cap != '0) begin
                                    r_inject <= 1'b1;
                                    r_state  <= S_SCAN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_tok[SLOTS].tv) begin
                        r_tok   <= w_tok[SLOTS];
                        r_tval  <= w_tval[SLOTS];
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_state <= S_DONE;
                    r_again <= 1'b0;
                    case (r_type)
                        lfuc_pkg::OP_GET: begin
                            if (!r_tok.hit) begin
                                r_miss <= r_miss + SW'(1);
                            end else if (w_expired) begin
                                r_cmd.op <= lfuc_pkg::C_KILL_HIT;
                                r_expire <= r_expire + SW'(1);
                                r_miss   <= r_miss + SW'(1);
                                r_count  <= r_count - CNT_W'(1);
                                r_state  <= S_APPLY;
                            end else begin
                                r_found     <= 1'b1;
                                r_vout      <= r_tval;
                                r_cmd.op    <= lfuc_pkg::C_TOUCH;
                                r_cmd.stamp <= r_tc;
                                r_tc        <= r_tc + TW'(1);
                                r_hit       <= r_hit + SW'(1);
                                r_state     <= S_APPLY;
                            end
                        end
                        lfuc_pkg::OP_PUT: begin
                            if (r_tok.hit) begin
                                r_cmd.op       <= lfuc_pkg::C_UPDATE;
                                r_cmd.stamp    <= r_tc;
                                r_cmd.expires  <= (r_eff != '0);
                                r_cmd.deadline <= (r_eff != '0) ? w_deadline : '0;
                                r_tc           <= r_tc + TW'(1);
                                r_state        <= S_APPLY;
                            end else if (!r_stamped) begin
                                r_new_stamp <= r_tc;
                                r_tc        <= r_tc + TW'(1);
                                r_total     <= w_cnt_ext + CAP_W'(1);
                                r_stamped   <= 1'b1;
                                r_state     <= S_DECIDE;
                            end else if (r_total > w_cap) begin
                                // the new entry itself may be the one to drop
                                if (r_pending && (!r_tok.mok ||
                                        r_tok.muses > lfuc_pkg::USES_W'(1) ||
                                        (r_tok.muses == lfuc_pkg::USES_W'(1) &&
                                         r_tok.mstamp > r_new_stamp))) begin
                                    r_pending <= 1'b0;
                                    r_evict   <= r_evict + SW'(1);
                                    r_total   <= r_total - CAP_W'(1);
                                    r_state   <= S_DECIDE;
                                end else if (r_tok.mok) begin
                                    r_cmd.op    <= lfuc_pkg::C_KILL_MIN;
                                    r_cmd.stamp <= r_tok.mstamp;
                                    r_evict     <= r_evict + SW'(1);
                                    r_total     <= r_total - CAP_W'(1);
                                    r_count     <= r_count - CNT_W'(1);
                                    r_again     <= 1'b1;
                                    r_state     <= S_APPLY;
                                end
                            end else if (r_pending) begin
                                r_cmd.op       <= lfuc_pkg::C_INSERT;
                                r_cmd.stamp    <= r_new_stamp;
                                r_cmd.expires  <= (r_eff != '0);
                                r_cmd.deadline <= (r_eff != '0) ? w_deadline : '0;
                                r_count        <= r_count + CNT_W'(1);
                                r_state        <= S_APPLY;
                            end
                        end
                        lfuc_pkg::OP_ERASE: begin
                            if (r_tok.hit) begin
                                r_cmd.op <= lfuc_pkg::C_KILL_HIT;
                                r_count  <= r_count - CNT_W'(1);
                                r_state  <= S_APPLY;
                            end
                        end
                        lfuc_pkg::OP_CONTAINS: begin
                            if (r_tok.hit && w_expired) begin
                                r_cmd.op <= lfuc_pkg::C_KILL_HIT;
                                r_expire <= r_expire + SW'(1);
                                r_count  <= r_count - CNT_W'(1);
                                r_state  <= S_APPLY;
                            end else if (r_tok.hit) begin
                                r_found <= 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_APPLY: begin
                    r_cmd.op <= lfuc_pkg::C_NOP;
                    if (r_again) begin
                        r_again  <= 1'b0;
                        r_inject <= 1'b1;
                        r_state  <= S_SCAN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // load the result word when leaving the done state
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ovalid || o_rsp.ready)) begin
            r_ofound  <= r_found;
            r_ovalue  <= 64'(r_vout);
            r_ocount  <= w_cnt_ext[6:0];
            r_ohit    <= r_hit;
            r_omiss   <= r_miss;
            r_oexpire <= r_expire;
            r_oevict  <= r_evict;
        end
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.found        = r_ofound;
    assign o_rsp.value_out    = r_ovalue;
    assign o_rsp.entry_count  = r_ocount;
    assign o_rsp.hit_total    = r_ohit;
    assign o_rsp.miss_total   = r_omiss;
    assign o_rsp.expire_total = r_oexpire;
    assign o_rsp.evict_total  = r_oevict;

`ifndef SYNTH
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt_ext <= CAP_W'(SLOTS))
        else $error("entry count above slot count");

    a_tail_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[SLOTS].tv |-> r_state == S_SCAN)
        else $error("scan token left the row outside a scan");

    a_insert_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.op == lfuc_pkg::C_INSERT |-> r_tok.free)
        else $error("insert issued with no free cell");

    a_cmd_in_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.op != lfuc_pkg::C_NOP |-> r_state == S_APPLY)
        else $error("cell command outside apply");
`endif

endmodule

>>> tb/sv/lfuc_checker.sv
`timescale 1ns / 1ps

module lfuc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfuc_req_if         i_req,
    lfuc_rsp_if         i_rsp,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    localparam int NSLOT = 64;

    typedef struct packed {
        logic        found;
        logic [63:0] value_out;
        logic [6:0]  entry_count;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] expire_total;
        logic [31:0] evict_total;
    } t_rsp;

    logic        sl_valid    [NSLOT];
    logic [63:0] sl_key      [NSLOT];
    logic [63:0] sl_value    [NSLOT];
    logic [31:0] sl_uses     [NSLOT];
    logic [47:0] sl_stamp    [NSLOT];
    logic        sl_expires  [NSLOT];
    logic [47:0] sl_deadline [NSLOT];
    logic [47:0] now_ms, touch_ctr;
    logic [31:0] n_hit, n_miss, n_exp, n_evict;
    logic [6:0]  cap_reg;
    logic [31:0] dttl_reg;
    t_rsp        rsp_queue[$];
    int          errors;

    assign o_errors  = errors;
    assign o_pending = rsp_queue.size();

    function automatic int lookup(logic [63:0] k);
        for (int i = 0; i < NSLOT; i++)
            if (sl_valid[i] && sl_key[i] == k) return i;
        return -1;
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < NSLOT; i++) n += sl_valid[i];
        return n;
    endfunction

    function automatic int lfu_victim();
        int b;
        b = -1;
        for (int i = 0; i < NSLOT; i++) begin
            if (!sl_valid[i]) continue;
            if (b < 0 || sl_uses[i] < sl_uses[b] ||
                (sl_uses[i] == sl_uses[b] && sl_stamp[i] < sl_stamp[b])) b = i;
        end
        return b;
    endfunction

    function automatic logic [47:0] take_stamp();
        logic [47:0] s;
        s = touch_ctr;
        touch_ctr = touch_ctr + 48'd1;
        return s;
    endfunction

    function automatic void bump(int i);
        if (sl_uses[i] != 32'hFFFF_FFFF) sl_uses[i]++;
        sl_stamp[i] = take_stamp();
    endfunction

    function automatic void arm(int i, logic [31:0] eff);
        sl_expires[i]  = eff != 0;
        sl_deadline[i] = (eff != 0) ? (now_ms + {16'd0, eff}) : '0;
    endfunction

    function automatic void do_store(logic [63:0] k, logic [63:0] v, logic [32:0] t);
        int cap, total, i, vi;
        logic [31:0] eff;
        logic [47:0] ns;
        logic pend;
        cap = (cap_reg > NSLOT) ? NSLOT : cap_reg;
        if (cap == 0) return;
        eff = t[32] ? dttl_reg : t[31:0];
        i = lookup(k);
        if (i >= 0) begin
            sl_value[i] = v;
            arm(i, eff);
            bump(i);
            return;
        end
        ns = take_stamp();
        total = live_count() + 1;
        pend = 1'b1;
        while (total > cap) begin
            vi = lfu_victim();
            if (pend && (vi < 0 || sl_uses[vi] > 1 ||
                         (sl_uses[vi] == 1 && sl_stamp[vi] > ns))) begin
                pend = 1'b0;
            end else if (vi >= 0) begin
                sl_valid[vi] = 1'b0;
            end else begin
                break;
            end
            n_evict++;
            total--;
        end
        if (!pend) return;
        for (int j = 0; j < NSLOT; j++) begin
            if (!sl_valid[j]) begin
                sl_valid[j] = 1'b1;
                sl_key[j] = k;
                sl_value[j] = v;
                sl_uses[j] = 32'd1;
                sl_stamp[j] = ns;
                arm(j, eff);
                return;
            end
        end
    endfunction

    function automatic t_rsp predict_rsp(logic [2:0] op, logic [63:0] k,
                                         logic [63:0] v, logic [32:0] t);
        t_rsp r;
        int i;
        r = '0;
        case (op)
            lfuc_pkg::OP_GET: begin
                i = lookup(k);
                if (i < 0) begin
                    n_miss++;
                end else if (sl_expires[i] && now_ms >= sl_deadline[i]) begin
                    sl_valid[i] = 1'b0;
                    n_exp++;
                    n_miss++;
                end else begin
                    r.found = 1'b1;
                    r.value_out = sl_value[i];
                    bump(i);
                    n_hit++;
                end
            end
            lfuc_pkg::OP_PUT: do_store(k, v, t);
            lfuc_pkg::OP_ERASE: begin
                i = lookup(k);
                if (i >= 0) sl_valid[i] = 1'b0;
            end
            lfuc_pkg::OP_CONTAINS: begin
                i = lookup(k);
                if (i >= 0) begin
                    if (sl_expires[i] && now_ms >= sl_deadline[i]) begin
                        sl_valid[i] = 1'b0;
                        n_exp++;
                    end else begin
                        r.found = 1'b1;
                    end
                end
            end
            lfuc_pkg::OP_TICK: now_ms = now_ms + 48'd1;
            default: ;
        endcase
        r.entry_count  = 7'(live_count());
        r.hit_total    = n_hit;
        r.miss_total   = n_miss;
        r.expire_total = n_exp;
        r.evict_total  = n_evict;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < NSLOT; i++) sl_valid[i] = 1'b0;
            now_ms = '0;
            touch_ctr = '0;
            n_hit = '0; n_miss = '0; n_exp = '0; n_evict = '0;
            cap_reg = 7'd64;
            dttl_reg = '0;
            rsp_queue.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == lfuc_pkg::REG_CAPACITY) cap_reg = i_cfg_data[6:0];
                else dttl_reg = i_cfg_data;
            end
            if (i_req.valid && i_req.ready)
                rsp_queue.push_back(predict_rsp(i_req.req_type, i_req.req_key,
                                                i_req.value_in, i_req.ttl));
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{i_rsp.found, i_rsp.value_out, i_rsp.entry_count,
                        i_rsp.hit_total, i_rsp.miss_total, i_rsp.expire_total,
                        i_rsp.evict_total};
                if (rsp_queue.size() == 0) begin
                    if (errors < 10) $display("unexpected word %p", got);
                    errors++;
                end else begin
                    want = rsp_queue.pop_front();
                    if (got !== want) begin
                        if (errors < 10) $display("mismatch exp %p got %p", want, got);
                        errors++;
                    end
                end
            end
        end
    end

    initial errors = 0;

endmodule

>>> tb/sv/lfu_cache_with_expiry_core_tb.sv
`timescale 1ns / 1ps

module lfu_cache_with_expiry_core_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [31:0] cfg_data = '0;
    int          errors, pending;
    int          stall_mode;
    logic [63:0] key_pool [8];

    lfuc_req_if req_ch();
    lfuc_rsp_if rsp_ch();

    lfu_cache_with_expiry_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch), .o_rsp(rsp_ch),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    lfuc_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch), .i_rsp(rsp_ch),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = '0;
        req_ch.req_key = '0;
        req_ch.value_in = '0;
        req_ch.ttl = '0;
        rsp_ch.ready = 1'b0;
    end

    // receiver stall pattern: changes mode now and then
    always @(negedge i_clk) begin
        case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
    end

    // drive a word and hold it until taken; valid stays up for a following word
    task automatic send_word(logic [2:0] op, logic [63:0] k, logic [63:0] v,
                             logic signed [32:0] t);
        req_ch.valid <= 1'b1;
        req_ch.req_type <= op;
        req_ch.req_key <= k;
        req_ch.value_in <= v;
        req_ch.ttl <= t;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] d);
        drain();
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= d;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [32:0] pick_ttl();
        case ($urandom_range(0, 5))
            0: return -33'sd1;
            1: return 33'sd0;
            2: return {1'b0, $urandom()};
            3: return {1'b1, $urandom()};
            default: return 33'($urandom_range(1, 12));
        endcase
    endfunction

    task automatic random_phase(int n);
        logic [2:0] op;
        logic [63:0] k;
        int burst;
        int gap;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    req_ch.valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                burst = $urandom_range(1, 12);
            end
            burst--;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5:   op = lfuc_pkg::OP_PUT;
                6, 7, 8, 9, 10, 11: op = lfuc_pkg::OP_GET;
                12, 13:             op = lfuc_pkg::OP_CONTAINS;
                14:                 op = lfuc_pkg::OP_ERASE;
                15, 16, 17:         op = lfuc_pkg::OP_TICK;
                default:            op = 3'($urandom_range(0, 7));
            endcase
            k = ($urandom_range(0, 9) == 0) ? {$urandom(), $urandom()}
                                            : key_pool[$urandom_range(0, 7)];
            send_word(op, k, {$urandom(), $urandom()}, pick_ttl());
        end
    endtask

    initial begin
        stall_mode = 0;
        for (int i = 0; i < 8; i++) key_pool[i] = {$urandom(), $urandom()};
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: every op, field extremes, expiry, overwrite, unused codes
        send_word(lfuc_pkg::OP_GET, '0, '0, '0);
        send_word(lfuc_pkg::OP_PUT, '0, '1, 33'sd2);
        send_word(lfuc_pkg::OP_PUT, '1, '0, 33'sd0);
        send_word(lfuc_pkg::OP_PUT, '1, 64'h5A5A, 33'sh0_FFFF_FFFF);
        send_word(lfuc_pkg::OP_GET, '1, '0, '0);
        send_word(lfuc_pkg::OP_CONTAINS, '0, '0, '0);
        send_word(lfuc_pkg::OP_TICK, '0, '0, '0);
        send_word(lfuc_pkg::OP_TICK, '0, '0, '0);
        send_word(lfuc_pkg::OP_CONTAINS, '0, '0, '0);
        send_word(lfuc_pkg::OP_PUT, '0, 64'h1, -33'sd1);
        send_word(lfuc_pkg::OP_GET, '0, '0, '0);
        send_word(lfuc_pkg::OP_ERASE, '0, '0, '0);
        send_word(lfuc_pkg::OP_ERASE, 64'h77, '0, '0);
        send_word(lfuc_pkg::OP_CONTAINS, '0, '0, '0);
        send_word(3'd5, '1, '1, '1);
        send_word(3'd7, '0, '0, '0);
        send_word(lfuc_pkg::OP_PUT, 64'h3, 64'h3, 33'sd1);
        send_word(lfuc_pkg::OP_TICK, '0, '0, '0);
        send_word(lfuc_pkg::OP_GET, 64'h3, '0, '0);

        write_reg(lfuc_pkg::REG_DEFAULT_TTL, 32'd3);
        write_reg(lfuc_pkg::REG_CAPACITY, 32'd2);
        random_phase(120);
        write_reg(lfuc_pkg::REG_CAPACITY, 32'd0);
        random_phase(30);
        write_reg(lfuc_pkg::REG_CAPACITY, 32'd127);
        write_reg(lfuc_pkg::REG_DEFAULT_TTL, 32'hFFFF_FFFF);
        random_phase(120);
        write_reg(lfuc_pkg::REG_CAPACITY, 32'd1);
        write_reg(lfuc_pkg::REG_DEFAULT_TTL, 32'd0);
        random_phase(80);
        write_reg(lfuc_pkg::REG_CAPACITY, 32'd5);
        write_reg(lfuc_pkg::REG_DEFAULT_TTL, 32'd6);
        random_phase(200);

        drain();
        if (errors == 0) begin
            $display("lfu_cache_with_expiry_core regression: pass");
        end else begin
            $display("lfu_cache_with_expiry_core regression: fail");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("lfu_cache_with_expiry_core regression: fail");
        $finish;
    end

endmodule
